### hw/rtl/wavp_pkg.sv
// Shared types, codes and constants for the WAV header parser and PCM scaler.
`default_nettype none

package wavp_pkg;

	// Parse phases
	localparam logic [3:0] PH_RIFF  = 4'd0;
	localparam logic [3:0] PH_RSIZE = 4'd1;
	localparam logic [3:0] PH_WAVE  = 4'd2;
	localparam logic [3:0] PH_CID   = 4'd3;
	localparam logic [3:0] PH_CSIZE = 4'd4;
	localparam logic [3:0] PH_FMT   = 4'd5;
	localparam logic [3:0] PH_SKIP  = 4'd6;
	localparam logic [3:0] PH_PAD   = 4'd7;
	localparam logic [3:0] PH_DATA  = 4'd8;
	localparam logic [3:0] PH_IDLE  = 4'd9;

	// Event codes
	localparam logic [2:0] EV_FRAME     = 3'd0;
	localparam logic [2:0] EV_HDR_OK    = 3'd1;
	localparam logic [2:0] EV_NOT_RIFF  = 3'd2;
	localparam logic [2:0] EV_NOT_WAVE  = 3'd3;
	localparam logic [2:0] EV_BAD_FMT   = 3'd4;
	localparam logic [2:0] EV_UNSUPP    = 3'd5;
	localparam logic [2:0] EV_FINISHED  = 3'd6;
	localparam logic [2:0] EV_TRUNCATED = 3'd7;

	// Chunk tags, big-endian as they arrive
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
	localparam logic [15:0] FMT_PCM      = 16'd1;
	localparam logic [15:0] FMT_BITS     = 16'd16;
	localparam logic [31:0] RATE_MIN     = 32'd8000;
	localparam logic [31:0] RATE_MAX     = 32'd48000;
	localparam logic [6:0]  VOL_MAX      = 7'd100;

	// Divide by 100 via reciprocal: q = (m * DIV_K) >> DIV_SHIFT, exact for m < 2^22
	localparam int          DIV_SHIFT = 29;
	localparam logic [22:0] DIV_K     = 23'd5368710;

	// Width of a sample times volume
	localparam int PROD_W = 23;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         event_res;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [15:0]        rate_hz;
		logic               stereo;
	} out_item_t;

	typedef struct packed {
		logic [3:0]                phase;
		logic [4:0]                cnt;
		logic [31:0]               tag;
		logic [31:0]               len;
		logic [15:0]               fmt_code;
		logic [15:0]               chan;
		logic [31:0]               rate;
		logic [15:0]               bits;
		logic                      fmt_ok;
		logic [31:0]               data_left;
		logic [7:0]                low;
		logic signed [PROD_W-1:0]  left_prod;
		logic                      rpend;
	} parse_state_t;

endpackage

`default_nettype wire

### hw/rtl/wavp_div100.sv
// Signed divide by 100, truncating toward zero, by reciprocal multiplication.
`default_nettype none

module wavp_div100 (
	input  wire logic signed [wavp_pkg::PROD_W-1:0] num,
	output logic signed [15:0]                      quo
);

	logic [wavp_pkg::PROD_W-1:0] mag;
	logic [45:0]                 prod;
	logic [15:0]                 q_mag;

	always_comb begin
		mag   = num[wavp_pkg::PROD_W-1] ? (~num + 1'b1) : num;
		prod  = {23'd0, mag} * {23'd0, wavp_pkg::DIV_K};
		q_mag = prod[wavp_pkg::DIV_SHIFT +: 16];
		quo   = num[wavp_pkg::PROD_W-1] ? $signed(~q_mag + 1'b1) : $signed(q_mag);
	end

endmodule

`default_nettype wire

### hw/rtl/wav_header_parse_and_pcm_scale.sv
// Top level: RIFF/WAVE PCM16 byte parser with volume scaling and stereo framing.
// Pipeline: a result passes through the stage 1 register and then the output register.
// Throughput: one byte per cycle while out_stall does not back up the pipe; the two-stage pipe
// (parse plus multiply, then reciprocal divide by 100) keeps bytes flowing while a result waits.
// Reset: arst_n clears the parse state, the pipe valids and sets volume to 100.
`default_nettype none

module wav_header_parse_and_pcm_scale (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire wavp_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output wavp_pkg::out_item_t      out_data,
	input  wire logic                cfg_wr_en,
	input  wire logic [6:0]          cfg_wr_data
);

	localparam wavp_pkg::parse_state_t PARSE_RESET = '0;

	// Volume register
	logic [6:0] vol_q;

	// Parse state
	wavp_pkg::parse_state_t st_q;
	wavp_pkg::parse_state_t cur;
	wavp_pkg::parse_state_t nx;

	// Stage 1: event and raw products
	logic                                 s1_valid_q;
	logic [2:0]                           ev_s1;
	logic signed [wavp_pkg::PROD_W-1:0]   lprod_s1;
	logic signed [wavp_pkg::PROD_W-1:0]   rprod_s1;
	logic [15:0]                          rate_s1;
	logic                                 stereo_s1;

	// Output register
	logic                out_valid_q;
	wavp_pkg::out_item_t out_q;

	// Handshake
	logic en1;
	logic en2;
	logic acc;

	// Combinational parse results
	logic                               emit;
	logic [2:0]                         ev;
	logic signed [wavp_pkg::PROD_W-1:0] lprod;
	logic signed [wavp_pkg::PROD_W-1:0] rprod;
	logic signed [15:0]                 lq;
	logic signed [15:0]                 rq;

	// Advance the output register when it is empty or its transfer completes;
	// advance stage 1 whenever it is empty or can move on.
	assign en2       = !out_valid_q || !out_stall;
	assign en1       = !s1_valid_q || en2;
	assign in_stall  = !en1;
	assign acc       = in_valid && en1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Volume: saturate writes above 100
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q <= wavp_pkg::VOL_MAX;
		end else if (cfg_wr_en) begin
			vol_q <= (cfg_wr_data > wavp_pkg::VOL_MAX) ? wavp_pkg::VOL_MAX : cfg_wr_data;
		end
	end

	// Byte parser: one state update per transferred byte
	always_comb begin
		logic [4:0]                         cnt1;
		logic [31:0]                        sz;
		logic [wavp_pkg::PROD_W-1:0]        prod;
		logic                               frame;
		logic                               close;

		cur   = in_data.first_byte ? PARSE_RESET : st_q;
		nx    = cur;
		emit  = 1'b0;
		ev    = wavp_pkg::EV_FRAME;
		lprod = '0;
		rprod = '0;
		cnt1  = cur.cnt + 5'd1;
		sz    = cur.len | ({24'd0, in_data.data_byte} << {cur.cnt[1:0], 3'b000});
		prod  = $signed({in_data.data_byte, cur.low}) * $signed({1'b0, vol_q});
		frame = 1'b0;
		close = 1'b0;

		case (cur.phase)
			wavp_pkg::PH_RIFF, wavp_pkg::PH_WAVE, wavp_pkg::PH_CID: begin
				nx.tag = {cur.tag[23:0], in_data.data_byte};
				nx.cnt = cnt1;
				if (cnt1 >= 5'd4) begin
					nx.cnt = '0;
					if (cur.phase == wavp_pkg::PH_RIFF) begin
						if (nx.tag != wavp_pkg::TAG_RIFF) begin
							nx.phase = wavp_pkg::PH_IDLE;
							emit     = 1'b1;
							ev       = wavp_pkg::EV_NOT_RIFF;
						end else begin
							nx.phase = wavp_pkg::PH_RSIZE;
						end
					end else if (cur.phase == wavp_pkg::PH_WAVE) begin
						if (nx.tag != wavp_pkg::TAG_WAVE) begin
							nx.phase = wavp_pkg::PH_IDLE;
							emit     = 1'b1;
							ev       = wavp_pkg::EV_NOT_WAVE;
						end else begin
							nx.phase = wavp_pkg::PH_CID;
						end
					end else begin
						nx.len   = '0;
						nx.phase = wavp_pkg::PH_CSIZE;
					end
				end
			end
			wavp_pkg::PH_RSIZE: begin
				nx.cnt = cnt1;
				if (cnt1 >= 5'd4) begin
					nx.cnt   = '0;
					nx.tag   = '0;
					nx.phase = wavp_pkg::PH_WAVE;
				end
			end
			wavp_pkg::PH_CSIZE: begin
				nx.len = sz;
				nx.cnt = cnt1;
				if (cnt1 >= 5'd4) begin
					nx.cnt = '0;
					if (cur.tag == wavp_pkg::TAG_FMT) begin
						if (sz < wavp_pkg::FMT_MIN_SIZE) begin
							nx.phase = wavp_pkg::PH_IDLE;
							emit     = 1'b1;
							ev       = wavp_pkg::EV_BAD_FMT;
						end else begin
							nx.fmt_code = '0;
							nx.chan     = '0;
							nx.rate     = '0;
							nx.bits     = '0;
							nx.tag      = {31'd0, sz[0]};
							nx.phase    = wavp_pkg::PH_FMT;
						end
					end else if (cur.tag == wavp_pkg::TAG_DATA) begin
						nx.data_left = sz;
						nx.rpend     = 1'b0;
						nx.phase     = wavp_pkg::PH_IDLE;
						emit         = 1'b1;
						if (!cur.fmt_ok) begin
							ev = wavp_pkg::EV_UNSUPP;
						end else if (sz == '0) begin
							ev = wavp_pkg::EV_FINISHED;
						end else if (in_data.last_byte) begin
							ev = wavp_pkg::EV_TRUNCATED;
						end else begin
							nx.phase = wavp_pkg::PH_DATA;
							ev       = wavp_pkg::EV_HDR_OK;
						end
					end else begin
						nx.tag = {31'd0, sz[0]};
						if (sz == '0) begin
							close = 1'b1;
						end else begin
							nx.phase = wavp_pkg::PH_SKIP;
						end
					end
				end
			end
			wavp_pkg::PH_FMT: begin
				case (cur.cnt)
					5'd0:  nx.fmt_code[7:0]  = in_data.data_byte;
					5'd1:  nx.fmt_code[15:8] = in_data.data_byte;
					5'd2:  nx.chan[7:0]      = in_data.data_byte;
					5'd3:  nx.chan[15:8]     = in_data.data_byte;
					5'd4:  nx.rate[7:0]      = in_data.data_byte;
					5'd5:  nx.rate[15:8]     = in_data.data_byte;
					5'd6:  nx.rate[23:16]    = in_data.data_byte;
					5'd7:  nx.rate[31:24]    = in_data.data_byte;
					5'd14: nx.bits[7:0]      = in_data.data_byte;
					5'd15: nx.bits[15:8]     = in_data.data_byte;
					default: ;
				endcase
				if (cur.cnt == 5'd15) begin
					nx.fmt_ok = (nx.fmt_code == wavp_pkg::FMT_PCM)
						&& (nx.bits == wavp_pkg::FMT_BITS)
						&& (nx.chan inside {16'd1, 16'd2})
						&& (nx.rate >= wavp_pkg::RATE_MIN)
						&& (nx.rate <= wavp_pkg::RATE_MAX);
				end
				if (cur.cnt < 5'd16) begin
					nx.cnt = cnt1;
				end
				nx.len = cur.len - 32'd1;
				close  = (nx.len == '0);
			end
			wavp_pkg::PH_SKIP: begin
				nx.len = cur.len - 32'd1;
				close  = (nx.len == '0);
			end
			wavp_pkg::PH_PAD: begin
				nx.tag   = '0;
				nx.cnt   = '0;
				nx.phase = wavp_pkg::PH_CID;
			end
			wavp_pkg::PH_DATA: begin
				nx.data_left = cur.data_left - 32'd1;
				if (!cur.cnt[0]) begin
					nx.low = in_data.data_byte;
				end else if (cur.chan != 16'd2) begin
					frame = 1'b1;
					lprod = prod[wavp_pkg::PROD_W-1:0];
					rprod = prod[wavp_pkg::PROD_W-1:0];
				end else if (!cur.rpend) begin
					nx.left_prod = prod[wavp_pkg::PROD_W-1:0];
					nx.rpend     = 1'b1;
				end else begin
					frame    = 1'b1;
					lprod    = cur.left_prod;
					rprod    = prod[wavp_pkg::PROD_W-1:0];
					nx.rpend = 1'b0;
				end
				nx.cnt = {4'd0, ~cur.cnt[0]};
				if (nx.data_left == '0) begin
					nx.phase = wavp_pkg::PH_IDLE;
					emit     = 1'b1;
					ev       = wavp_pkg::EV_FINISHED;
				end else if (in_data.last_byte) begin
					nx.phase = wavp_pkg::PH_IDLE;
					emit     = 1'b1;
					ev       = wavp_pkg::EV_TRUNCATED;
				end else begin
					emit = frame;
					ev   = wavp_pkg::EV_FRAME;
				end
			end
			default: ;
		endcase

		// End of a chunk body: go to the pad byte if the length was odd
		if (close) begin
			nx.phase = (cur.tag != '0 || nx.tag != '0) && cur.phase != wavp_pkg::PH_CSIZE
				? wavp_pkg::PH_PAD : wavp_pkg::PH_CID;
			nx.tag   = '0;
			nx.cnt   = '0;
		end

		// File ends inside the header
		if (!emit && in_data.last_byte && nx.phase != wavp_pkg::PH_IDLE) begin
			emit = 1'b1;
			if (nx.phase == wavp_pkg::PH_RIFF) begin
				ev = wavp_pkg::EV_NOT_RIFF;
			end else if (nx.phase == wavp_pkg::PH_RSIZE || nx.phase == wavp_pkg::PH_WAVE) begin
				ev = wavp_pkg::EV_NOT_WAVE;
			end else begin
				ev = wavp_pkg::EV_UNSUPP;
			end
			nx.phase = wavp_pkg::PH_IDLE;
		end
	end

	// Parse state: advance on every transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= PARSE_RESET;
		end else if (acc) begin
			st_q <= nx;
		end
	end

	// Stage 1 register: hold while it is full and the output side is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (en1) begin
			s1_valid_q <= acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ev_s1     <= ev;
			lprod_s1  <= lprod;
			rprod_s1  <= rprod;
			rate_s1   <= nx.rate[15:0];
			stereo_s1 <= (nx.chan == 16'd2);
		end
	end

	// Stage 2: divide both products by 100
	wavp_div100 u_div_left (
		.num (lprod_s1),
		.quo (lq)
	);

	wavp_div100 u_div_right (
		.num (rprod_s1),
		.quo (rq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en2) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			out_q.event_res    <= ev_s1;
			out_q.left_sample  <= lq;
			out_q.right_sample <= rq;
			out_q.rate_hz      <= rate_s1;
			out_q.stereo       <= stereo_s1;
		end
	end

endmodule

`default_nettype wire
